[rtl/depthwise_conv3x3_padded_assert.svh]
// Assertion macros for the depthwise 3x3 convolution block.
// Included by the top level; expects clk and rst in scope.
`ifndef DEPTHWISE_CONV3X3_PADDED_ASSERT_SVH
`define DEPTHWISE_CONV3X3_PADDED_ASSERT_SVH

`ifndef SYNTH
// Check that a property holds on every edge outside reset
`define DWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition holds in the cycle after a trigger
`define DWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DWC_ASSERT(lbl, prop, msg)
`define DWC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/dwc_pkg.sv]
// Shared types and constants for the depthwise 3x3 convolution block.
// No dependencies.
package dwc_pkg;

  // Item modes
  localparam logic [1:0] MODE_WEIGHT = 2'd0;
  localparam logic [1:0] MODE_PIXEL  = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  // Register indexes (decoded from paddr[2])
  localparam logic REG_ACTIVE_HEIGHT = 1'b0;
  localparam logic REG_ACTIVE_WIDTH  = 1'b1;

  localparam int KERN_DIM = 3;
  localparam int KTAPS    = KERN_DIM * KERN_DIM;

  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int SUM_W  = 35;
  localparam int SIZE_W = 6;
  // Wide enough for a neighbour position up to the largest image dimension
  localparam int DIM_W  = 9;

  // Control for the shared multiply-accumulate unit
  typedef struct packed {
    logic clear;   // zero the accumulator
    logic en;      // a tap arrives this cycle
    logic tap_ok;  // tap lies inside the active image
  } mac_ctl_t;

endpackage

[rtl/dwc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dwc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/dwc_mac.sv]
// Shared multiply-accumulate unit: registered Q16.16 product, Q19.16 accumulator.
// Depends on dwc_pkg.
module dwc_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  dwc_pkg::mac_ctl_t                 ctl,
  input  logic signed [dwc_pkg::VAL_W-1:0]  pixel,
  input  logic signed [dwc_pkg::VAL_W-1:0]  weight,
  output logic signed [dwc_pkg::SUM_W-1:0]  acc
);
  import dwc_pkg::*;

  logic signed [PROD_W-1:0] mult;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;

  // Signed product of one pixel and one weight
  assign mult = pixel * weight;

  // Multiply stage: drop taps outside the image
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.en;
    end
    prod <= ctl.tap_ok ? mult : '0;
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + {{(SUM_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

endmodule

[rtl/depthwise_conv3x3_padded.sv]
// Depthwise 3x3 convolution, zero padding of one, stride one, on Q8.8 data.
// Weight and pixel writes (modes 0 and 1) give no transaction on the output.
// A query (mode 2) walks the nine kernel taps through one shared
// multiply-accumulate unit, reading one pixel and one weight per cycle from
// the two RAMs; the taps pass the RAM read, the product register and the
// accumulator, and the result then enters the output register (later while
// an earlier result still waits there); the block takes no new item meanwhile.
// The result sits in an output register, so further items are taken while
// it waits. Neighbours outside active_height x active_width count as zero.
// Depends on dwc_pkg, dwc_ram, dwc_mac and depthwise_conv3x3_padded_assert.svh.
`include "depthwise_conv3x3_padded_assert.svh"

module depthwise_conv3x3_padded #(
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_HEIGHT   = 32,
  parameter int MAX_WIDTH    = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // Item channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              mode,
  input  logic [1:0]                              channel,
  input  logic [4:0]                              row,
  input  logic [4:0]                              col,
  input  logic signed [dwc_pkg::VAL_W-1:0]        value,
  // Result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [dwc_pkg::SUM_W-1:0]        conv_sum,
  // Register port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [2:0]                              paddr,
  input  logic [31:0]                             pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);
  import dwc_pkg::*;

  localparam int PLANE     = MAX_HEIGHT * MAX_WIDTH;
  localparam int PIX_DEPTH = MAX_CHANNELS * PLANE;
  localparam int PIX_AW    = $clog2(PIX_DEPTH);
  localparam int WT_DEPTH  = MAX_CHANNELS * KTAPS;
  localparam int WT_AW     = $clog2(WT_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  localparam logic [1:0] TAP_LAST = 2'(KERN_DIM - 1);

  // Registers
  logic [SIZE_W-1:0] active_height;
  logic [SIZE_W-1:0] active_width;
  logic [1:0]        state;
  logic [1:0]        q_channel;
  logic [4:0]        q_row;
  logic [4:0]        q_col;
  logic [1:0]        tap_r;
  logic [1:0]        tap_c;
  logic              s1_valid;
  logic              s1_ok;
  logic              s1_last;
  logic              s2_last;
  logic              sum_ready;

  logic              in_accept;
  logic              ch_ok;
  logic              wt_we;
  logic              pix_we;
  logic [WT_AW-1:0]  wt_waddr;
  logic [PIX_AW-1:0] pix_waddr;
  logic [WT_AW-1:0]  wt_raddr;
  logic [PIX_AW-1:0] pix_raddr;
  logic [VAL_W-1:0]  wt_rdata;
  logic [VAL_W-1:0]  pix_rdata;
  logic [DIM_W-1:0]  nb_r;
  logic [DIM_W-1:0]  nb_c;
  logic              issue_ok;
  logic              issue_last;
  logic              out_free;
  logic              out_load;
  logic              cfg_write;
  mac_ctl_t          mac_ctl;
  logic signed [SUM_W-1:0] acc;

  // Register port: decode and read back
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_height <= SIZE_W'(5);
      active_width  <= SIZE_W'(5);
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_ACTIVE_HEIGHT: active_height <= pwdata[SIZE_W-1:0];
        REG_ACTIVE_WIDTH:  active_width  <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ACTIVE_HEIGHT: prdata = {{(32 - SIZE_W){1'b0}}, active_height};
      REG_ACTIVE_WIDTH:  prdata = {{(32 - SIZE_W){1'b0}}, active_width};
      default:           prdata = '0;
    endcase
  end

  // Input handshake and store writes
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign ch_ok     = 32'(channel) < 32'(MAX_CHANNELS);

  assign wt_we  = in_accept && (mode == MODE_WEIGHT) && ch_ok
                  && (32'(row) < 32'(KERN_DIM)) && (32'(col) < 32'(KERN_DIM));
  assign pix_we = in_accept && (mode == MODE_PIXEL) && ch_ok
                  && (32'(row) < 32'(MAX_HEIGHT)) && (32'(col) < 32'(MAX_WIDTH));

  assign wt_waddr  = WT_AW'(channel) * WT_AW'(KTAPS) + WT_AW'(row[1:0]) * WT_AW'(KERN_DIM)
                     + WT_AW'(col[1:0]);
  assign pix_waddr = PIX_AW'(channel) * PIX_AW'(PLANE) + PIX_AW'(row) * PIX_AW'(MAX_WIDTH)
                     + PIX_AW'(col);

  // Neighbour position, offset by one so that zero means above or left of the image
  assign nb_r = DIM_W'(q_row) + DIM_W'(tap_r);
  assign nb_c = DIM_W'(q_col) + DIM_W'(tap_c);

  assign issue_ok = (32'(q_channel) < 32'(MAX_CHANNELS))
                    && (nb_r != '0) && (nb_r <= DIM_W'(active_height))
                    && (nb_r <= DIM_W'(MAX_HEIGHT))
                    && (nb_c != '0) && (nb_c <= DIM_W'(active_width))
                    && (nb_c <= DIM_W'(MAX_WIDTH));
  assign issue_last = (tap_r == TAP_LAST) && (tap_c == TAP_LAST);

  assign wt_raddr  = WT_AW'(q_channel) * WT_AW'(KTAPS) + WT_AW'(tap_r) * WT_AW'(KERN_DIM)
                     + WT_AW'(tap_c);
  assign pix_raddr = PIX_AW'(q_channel) * PIX_AW'(PLANE)
                     + PIX_AW'(nb_r - DIM_W'(1)) * PIX_AW'(MAX_WIDTH)
                     + PIX_AW'(nb_c - DIM_W'(1));

  dwc_ram #(.WIDTH(VAL_W), .DEPTH(WT_DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (value),
    .raddr (wt_raddr),
    .rdata (wt_rdata)
  );

  dwc_ram #(.WIDTH(VAL_W), .DEPTH(PIX_DEPTH)) u_pixel_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (value),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  // Sequencer: walk the nine taps, then wait for the accumulator
  assign out_free = ~out_valid | ~out_stall;
  assign out_load = (state == ST_WAIT) && sum_ready && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tap_r <= '0;
      tap_c <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept && (mode == MODE_QUERY)) begin
            state <= ST_RUN;
            tap_r <= '0;
            tap_c <= '0;
          end
        end
        ST_RUN: begin
          if (tap_c == TAP_LAST) begin
            tap_c <= '0;
            tap_r <= tap_r + 2'd1;
          end else begin
            tap_c <= tap_c + 2'd1;
          end
          if (issue_last) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Hold the query position
  always_ff @(posedge clk) begin
    if (in_accept && (mode == MODE_QUERY)) begin
      q_channel <= channel;
      q_row     <= row;
      q_col     <= col;
    end
  end

  // Align tap flags with the RAM read data, then with the product
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_last   <= 1'b0;
      s2_last   <= 1'b0;
      sum_ready <= 1'b0;
    end else begin
      s1_valid <= (state == ST_RUN);
      s1_last  <= (state == ST_RUN) && issue_last;
      s2_last  <= s1_last;
      if (s2_last) begin
        sum_ready <= 1'b1;
      end else if (out_load) begin
        sum_ready <= 1'b0;
      end
    end
    s1_ok <= issue_ok;
  end

  assign mac_ctl.clear  = in_accept && (mode == MODE_QUERY);
  assign mac_ctl.en     = s1_valid;
  assign mac_ctl.tap_ok = s1_ok;

  dwc_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .pixel  (pix_rdata),
    .weight (wt_rdata),
    .acc    (acc)
  );

  // Output register: load the finished sum, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      conv_sum <= acc;
    end
  end

  `DWC_ASSERT(a_ready_only_waiting, sum_ready |-> (state == ST_WAIT), "sum ready outside wait")
  `DWC_ASSERT(a_taps_block_input, s1_valid |-> in_stall, "input taken while taps in flight")
  `DWC_ASSERT_NEXT(a_load_frees, out_load, out_valid && (state == ST_IDLE), "load did not complete")

endmodule
